// ===== design/cbq_pkg.sv =====
// Shared types, constants and helper functions for the cascaded biquad filter.
`default_nettype none

package cbq_pkg;

    // Number formats and sizes.
    localparam int SAMPLE_W     = 24;
    localparam int COEF_W       = 32;
    localparam int MAX_SECTIONS = 16;
    localparam int NUM_COEFS    = 5;
    localparam int HIST_PER_SEC = 4;
    localparam int COEF_DEPTH   = NUM_COEFS * MAX_SECTIONS;
    localparam int HIST_DEPTH   = HIST_PER_SEC * MAX_SECTIONS;
    localparam int COEF_AW      = $clog2(COEF_DEPTH);
    localparam int HIST_AW      = $clog2(HIST_DEPTH);
    localparam int SEC_W        = $clog2(MAX_SECTIONS);
    localparam int SEC_IDX_W    = 4;
    localparam int SEL_W        = 3;
    localparam int CNT_W        = 5;
    localparam int PROD_W       = SAMPLE_W + COEF_W;
    localparam int ACC_W        = PROD_W + 3;
    localparam int FRAC_SHIFT   = COEF_W - 2;

    // Input stream packing, lowest bit first.
    localparam int IN_SAMPLE_LSB = 0;
    localparam int IN_SEC_LSB    = IN_SAMPLE_LSB + SAMPLE_W;
    localparam int IN_SEL_LSB    = IN_SEC_LSB + SEC_IDX_W;
    localparam int IN_COEF_LSB   = IN_SEL_LSB + SEL_W;
    localparam int IN_FIELDS_W   = IN_COEF_LSB + COEF_W;
    localparam int IN_DATA_W     = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W    = ((SAMPLE_W + 7) / 8) * 8;

    // Configuration port.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic [APB_ADDR_W-1:0] ADDR_SECTION_COUNT = 3'd0;

    // Commands carried in tuser.
    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    // Coefficient selects.
    localparam logic [SEL_W-1:0] SEL_B0 = 3'd0;
    localparam logic [SEL_W-1:0] SEL_B1 = 3'd1;
    localparam logic [SEL_W-1:0] SEL_B2 = 3'd2;
    localparam logic [SEL_W-1:0] SEL_A1 = 3'd3;
    localparam logic [SEL_W-1:0] SEL_A2 = 3'd4;

    // Control of the shared multiply-accumulate unit.
    typedef struct packed {
        logic load;
        logic accum;
        logic sub;
    } t_mac_ctrl;

    // Round half up, drop the fraction bits and saturate to the sample width.
    function automatic logic signed [SAMPLE_W-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0] rounded;
        logic signed [ACC_W-1:0] shifted;
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        rounded = acc + (ACC_W'(1) <<< (FRAC_SHIFT - 1));
        shifted = rounded >>> FRAC_SHIFT;
        hi = ACC_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
        lo = -hi - ACC_W'(1);
        if (shifted > hi) begin
            round_sat = hi[SAMPLE_W-1:0];
        end else if (shifted < lo) begin
            round_sat = lo[SAMPLE_W-1:0];
        end else begin
            round_sat = shifted[SAMPLE_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/cascaded_biquad_filter.sv =====
// Top level of the cascaded biquad filter: sequencer, state memories and ports.
`default_nettype none

// Cascade of up to 16 direct form I biquad sections sharing one multiply-accumulate
// unit. Coefficients and section history live in two RAMs with registered reads.
// A sample transaction runs through each active section in turn between an accept
// step and an output step; its length is set by the five products of each section
// passing through the single MAC and the single write port of the history RAM. A
// coefficient load transaction produces no output. After reset the block clears
// both RAMs to zero, during which s_axis_tready stays low; APB writes are accepted
// at any time. A finished sample is held in an output register, so the next
// transaction can be accepted while it waits on m_axis_tready.
module cascaded_biquad_filter
    import cbq_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // APB configuration port.
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    // Input stream.
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata: sample_in[23:0], section_index[27:24], coef_select[30:28],
    //        coef_value[62:31], zero pad[63]
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: command[0]
    input  wire logic [0:0]            s_axis_tuser,
    // Output stream.
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // tdata: sample_out[23:0]
    output logic      [OUT_DATA_W-1:0] m_axis_tdata
);

    // Sequencer states.
    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_RUN    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    // Steps within one section.
    localparam logic [2:0] STEP_ACC_FIRST = 3'd2;
    localparam logic [2:0] STEP_WR_X1     = 3'd2;
    localparam logic [2:0] STEP_WR_X2     = 3'd3;
    localparam logic [2:0] STEP_CAP_Y1    = 3'd4;
    localparam logic [2:0] STEP_WR_Y2     = 3'd5;
    localparam logic [2:0] STEP_LAST      = 3'd7;

    // History slots within one section.
    localparam logic [1:0] SLOT_X1 = 2'd0;
    localparam logic [1:0] SLOT_X2 = 2'd1;
    localparam logic [1:0] SLOT_Y1 = 2'd2;
    localparam logic [1:0] SLOT_Y2 = 2'd3;

    logic [1:0]                  r_state;
    logic [2:0]                  r_step;
    logic [SEC_W-1:0]            r_sec;
    logic [SEC_W-1:0]            r_last_sec;
    logic [COEF_AW-1:0]          r_clr_cnt;
    logic [CNT_W-1:0]            r_section_count;
    logic signed [SAMPLE_W-1:0]  r_x;
    logic signed [SAMPLE_W-1:0]  r_h0;
    logic signed [SAMPLE_W-1:0]  r_h2;
    logic                        r_out_valid;
    logic [SAMPLE_W-1:0]         r_out_data;

    logic                        s_accept;
    logic                        in_cmd;
    logic signed [SAMPLE_W-1:0]  in_sample;
    logic [SEC_IDX_W-1:0]        in_sec;
    logic [SEL_W-1:0]            in_sel;
    logic [COEF_W-1:0]           in_coef;
    logic [CNT_W-1:0]            active_count;
    logic                        load_ok;

    logic                        coef_we;
    logic [COEF_AW-1:0]          coef_waddr;
    logic [COEF_W-1:0]           coef_wdata;
    logic [COEF_AW-1:0]          coef_raddr;
    logic [COEF_W-1:0]           coef_rdata;
    logic                        hist_we;
    logic [HIST_AW-1:0]          hist_waddr;
    logic [SAMPLE_W-1:0]         hist_wdata;
    logic [HIST_AW-1:0]          hist_raddr;
    logic [SAMPLE_W-1:0]         hist_rdata;

    t_mac_ctrl                   mac_ctrl;
    logic signed [SAMPLE_W-1:0]  mac_samp;
    logic signed [SAMPLE_W-1:0]  mac_y;
    logic                        cfg_write;

    // Input field unpacking.
    assign in_cmd    = s_axis_tuser[0];
    assign in_sample = s_axis_tdata[IN_SAMPLE_LSB +: SAMPLE_W];
    assign in_sec    = s_axis_tdata[IN_SEC_LSB +: SEC_IDX_W];
    assign in_sel    = s_axis_tdata[IN_SEL_LSB +: SEL_W];
    assign in_coef   = s_axis_tdata[IN_COEF_LSB +: COEF_W];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // Sections in use, limited to what the RAMs hold.
    assign active_count = (r_section_count > CNT_W'(MAX_SECTIONS)) ?
                          CNT_W'(MAX_SECTIONS) : r_section_count;

    // A load outside the stored sections or coefficients is dropped.
    assign load_ok = (CNT_W'(in_sec) < CNT_W'(MAX_SECTIONS)) &&
                     (in_sel inside {SEL_B0, SEL_B1, SEL_B2, SEL_A1, SEL_A2});

    // APB register access.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = APB_DATA_W'(r_section_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_section_count <= '0;
        end else if (cfg_write && (paddr == ADDR_SECTION_COUNT)) begin
            r_section_count <= pwdata[CNT_W-1:0];
        end
    end

    // Coefficient RAM port selection: clearing sweep or load transaction.
    always_comb begin
        coef_we    = 1'b0;
        coef_waddr = r_clr_cnt;
        coef_wdata = '0;
        if (r_state == ST_CLEAR) begin
            coef_we = 1'b1;
        end else if (s_accept && (in_cmd == CMD_LOAD) && load_ok) begin
            coef_we    = 1'b1;
            coef_waddr = COEF_AW'({in_sec, 2'b00}) + COEF_AW'(in_sec) + COEF_AW'(in_sel);
            coef_wdata = in_coef;
        end
    end

    assign coef_raddr = COEF_AW'({r_sec, 2'b00}) + COEF_AW'(r_sec) + COEF_AW'(r_step);

    // History RAM: read h(step-1), write back the shifted history in fixed steps.
    assign hist_raddr = {r_sec, r_step[1:0] - 2'd1};

    always_comb begin
        hist_we    = 1'b0;
        hist_waddr = r_clr_cnt[HIST_AW-1:0];
        hist_wdata = '0;
        if (r_state == ST_CLEAR) begin
            hist_we = (r_clr_cnt < COEF_AW'(HIST_DEPTH));
        end else if (r_state == ST_RUN) begin
            case (r_step)
                STEP_WR_X1: begin
                    hist_we    = 1'b1;
                    hist_waddr = {r_sec, SLOT_X1};
                    hist_wdata = r_x;
                end
                STEP_WR_X2: begin
                    hist_we    = 1'b1;
                    hist_waddr = {r_sec, SLOT_X2};
                    hist_wdata = r_h0;
                end
                STEP_WR_Y2: begin
                    hist_we    = 1'b1;
                    hist_waddr = {r_sec, SLOT_Y2};
                    hist_wdata = r_h2;
                end
                STEP_LAST: begin
                    hist_we    = 1'b1;
                    hist_waddr = {r_sec, SLOT_Y1};
                    hist_wdata = mac_y;
                end
                default: begin
                    hist_we = 1'b0;
                end
            endcase
        end
    end

    cbq_ram #(
        .WIDTH (COEF_W),
        .DEPTH (COEF_DEPTH),
        .AW    (COEF_AW)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (coef_waddr),
        .i_wdata (coef_wdata),
        .i_raddr (coef_raddr),
        .o_rdata (coef_rdata)
    );

    cbq_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (HIST_DEPTH),
        .AW    (HIST_AW)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_raddr (hist_raddr),
        .o_rdata (hist_rdata)
    );

    // MAC operands and control: b0 pairs with the section input, the rest with history.
    assign mac_samp = (r_step == 3'd1) ? r_x : hist_rdata;

    always_comb begin
        mac_ctrl       = '0;
        mac_ctrl.load  = (r_state == ST_RUN) && (r_step == STEP_ACC_FIRST);
        mac_ctrl.accum = (r_state == ST_RUN) && (r_step inside {[3'd3:3'd6]});
        mac_ctrl.sub   = (r_step inside {3'd5, 3'd6});
    end

    cbq_mac u_mac (
        .i_clk  (i_clk),
        .i_coef (coef_rdata),
        .i_samp (mac_samp),
        .i_ctrl (mac_ctrl),
        .o_y    (mac_y)
    );

    // Sequencer control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_step     <= '0;
            r_sec      <= '0;
            r_last_sec <= '0;
            r_clr_cnt  <= '0;
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    if (r_clr_cnt == COEF_AW'(COEF_DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                    r_clr_cnt <= r_clr_cnt + COEF_AW'(1);
                end
                ST_IDLE: begin
                    if (s_accept && (in_cmd == CMD_FILTER)) begin
                        r_step     <= '0;
                        r_sec      <= '0;
                        r_last_sec <= SEC_W'(active_count - CNT_W'(1));
                        r_state    <= (active_count == '0) ? ST_FINISH : ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (r_step == STEP_LAST) begin
                        r_step <= '0;
                        if (r_sec == r_last_sec) begin
                            r_state <= ST_FINISH;
                        end else begin
                            r_sec <= r_sec + SEC_W'(1);
                        end
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                ST_FINISH: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Sample path registers: section input and the two history values carried forward.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_x <= in_sample;
        end else if ((r_state == ST_RUN) && (r_step == STEP_LAST)) begin
            r_x <= mac_y;
        end
        if ((r_state == ST_RUN) && (r_step == STEP_WR_X1)) begin
            r_h0 <= hist_rdata;
        end
        if ((r_state == ST_RUN) && (r_step == STEP_CAP_Y1)) begin
            r_h2 <= hist_rdata;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_FINISH) && (!r_out_valid || m_axis_tready)) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_FINISH) && (!r_out_valid || m_axis_tready)) begin
            r_out_data <= r_x;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'(r_out_data);

    // The history RAM is written only by the clearing sweep or a running sample.
    a_hist_we_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hist_we |-> ((r_state == ST_CLEAR) || (r_state == ST_RUN)))
        else $error("history write outside clear or run");

    // A sample with no active sections goes straight to the output stage.
    a_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && (in_cmd == CMD_FILTER) && (active_count == '0))
        |=> (r_state == ST_FINISH))
        else $error("bypass sample did not skip the sections");

    // The running section never passes the last active one.
    a_sec_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_sec <= r_last_sec))
        else $error("section index past the last active section");

    // A new output only appears from the output stage.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == ST_FINISH))
        else $error("output valid raised outside the output stage");

endmodule

`default_nettype wire

// ===== design/cbq_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module cbq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/cbq_mac.sv =====
// Shared multiply-accumulate unit with registered product, accumulator and output rounding.
`default_nettype none

module cbq_mac
    import cbq_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic signed [COEF_W-1:0]   i_coef,
    input  wire logic signed [SAMPLE_W-1:0] i_samp,
    input  wire t_mac_ctrl                  i_ctrl,
    output logic signed [SAMPLE_W-1:0]      o_y
);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W-1:0]  prod_ext;

    // One product per cycle, registered before it is summed.
    assign n_prod   = i_coef * i_samp;
    assign prod_ext = ACC_W'(r_prod);

    // Accumulate: the first term loads, feedback terms subtract.
    always_comb begin
        n_acc = r_acc;
        if (i_ctrl.load) begin
            n_acc = prod_ext;
        end else if (i_ctrl.accum) begin
            if (i_ctrl.sub) begin
                n_acc = r_acc - prod_ext;
            end else begin
                n_acc = r_acc + prod_ext;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_acc  <= n_acc;
    end

    // Section output, rounded and saturated.
    assign o_y = round_sat(r_acc);

endmodule

`default_nettype wire
